/* rtl/core/akf_pkg.sv */
// Shared constants, codes and types for the angle Kalman filter.
// Used by akf_serial_unit, angle_kalman_filter and akf_port_checker; depends on nothing.
package akf_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int NOISE_W        = 24;
    localparam int ANGLE_W        = 32;
    localparam int DT_W           = 24;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int FRAC_COV       = 28;

    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_NOISE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_NOISE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE_NOISE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE   = 2'd3;

    localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST   = 24'd16777;
    localparam logic [NOISE_W-1:0] BIAS_NOISE_RST    = 24'd50332;
    localparam logic [NOISE_W-1:0] MEASURE_NOISE_RST = 24'd503316;

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    localparam logic [1:0] SH_20 = 2'd0;
    localparam logic [1:0] SH_24 = 2'd1;
    localparam logic [1:0] SH_28 = 2'd2;

    typedef struct packed {
        logic       start;
        logic       op;
        logic [1:0] shift;
    } t_au_ctrl;

    function automatic int sh_amount(input logic [1:0] code);
        int amt;
        case (code)
            SH_20:   amt = 20;
            SH_24:   amt = 24;
            default: amt = 28;
        endcase
        return amt;
    endfunction

endpackage

/* rtl/core/akf_serial_unit.sv */
// Bit-serial sign-magnitude multiplier with rounding and restoring divider.
// Depends on akf_pkg.
module akf_serial_unit #(
    parameter int DATA_WIDTH = akf_pkg::DATA_WIDTH_DEF,
    localparam int OW = ((DATA_WIDTH > 29) ? DATA_WIDTH : 29) + 2,
    localparam int EW = ((DATA_WIDTH > 29) ? DATA_WIDTH : 29) + 5
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  akf_pkg::t_au_ctrl     i_ctrl,
    input  logic signed [OW-1:0]  i_a,
    input  logic signed [OW-1:0]  i_b,
    output logic                  o_done,
    output logic signed [EW-1:0]  o_result
);
    import akf_pkg::*;

    localparam int MB = OW;
    localparam int QW = OW + FRAC_COV;
    localparam int CW = $clog2(QW + 1);
    localparam int PW = 2 * MB + 1;
    localparam logic [PW-1:0] LIM = PW'(1) << (EW - 3);
    localparam logic [QW-1:0] QLIM = QW'(1) << (DATA_WIDTH - 1);

    logic              r_busy, r_done, r_op, r_neg;
    logic [1:0]        r_shift;
    logic [CW-1:0]     r_cnt;
    logic [MB-1:0]     r_mcand;
    logic [PW-1:0]     r_prod;
    logic [QW-1:0]     r_quo;
    logic [MB-1:0]     r_rem;
    logic signed [EW-1:0] r_result;

    logic [MB-1:0] ma, mb;
    logic [MB:0]   sum;
    logic [MB+1:0] diff;
    logic          ge;
    logic [PW-1:0] rnd, qm;
    logic [EW-1:0] mag, mul_res, div_res;

    always_comb begin
        ma   = i_a[OW-1] ? MB'(~i_a + 1'b1) : MB'(i_a);
        mb   = i_b[OW-1] ? MB'(~i_b + 1'b1) : MB'(i_b);
        sum  = {1'b0, r_prod[2*MB-1:MB]} + (r_prod[0] ? {1'b0, r_mcand} : '0);
        diff = {1'b0, r_rem, r_quo[QW-1]} - {2'b00, r_mcand};
        ge   = !diff[MB+1];
        // Round half away from zero on the magnitude, then cap it.
        rnd  = {1'b0, r_prod[2*MB-1:0]} + (PW'(1) << (sh_amount(r_shift) - 1));
        qm   = rnd >> sh_amount(r_shift);
        mag  = (qm > LIM) ? EW'(LIM) : EW'(qm);
        mul_res = r_neg ? (~mag + 1'b1) : mag;
        if (r_mcand == '0) begin
            div_res = '0;
        end else if (r_quo >= QLIM) begin
            div_res = r_neg ? (~EW'(QLIM) + 1'b1) : (EW'(QLIM) - 1'b1);
        end else begin
            div_res = r_neg ? (~EW'(r_quo) + 1'b1) : EW'(r_quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctrl.start) begin
                r_busy  <= 1'b1;
                r_op    <= i_ctrl.op;
                r_shift <= i_ctrl.shift;
                r_neg   <= i_a[OW-1] ^ i_b[OW-1];
                if (i_ctrl.op == OP_MUL) begin
                    r_mcand <= ma;
                    r_prod  <= {{(MB+1){1'b0}}, mb};
                    r_cnt   <= CW'(MB);
                end else begin
                    r_mcand <= mb;
                    r_quo   <= {ma, {FRAC_COV{1'b0}}};
                    r_rem   <= '0;
                    r_cnt   <= CW'(QW);
                end
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - 1'b1;
                    if (r_op == OP_MUL) begin
                        r_prod <= {1'b0, sum, r_prod[MB-1:1]};
                    end else begin
                        r_rem <= ge ? diff[MB-1:0] : {r_rem[MB-2:0], r_quo[QW-1]};
                        r_quo <= {r_quo[QW-2:0], ge};
                    end
                end else begin
                    r_busy   <= 1'b0;
                    r_done   <= 1'b1;
                    r_result <= (r_op == OP_MUL) ? mul_res : div_res;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

/* rtl/core/angle_kalman_filter.sv */
// Top level of the two-state angle and gyro-bias Kalman filter.
// Depends on akf_pkg and akf_serial_unit.
//
//  channel  direction  handshake                   payload
//  in       sink       i_in_valid / o_in_ready     measured angle, gyro rate, time step
//  out      source     o_out_valid / i_out_ready   filtered angle
//  cfg      sink       i_cfg_we                    register index and data
//
// Each word runs through ten serial multiplies and two serial divides on one
// shared unit, one operation after another.
// Reset is synchronous and active low; it restores the register defaults
// and clears the estimates and the covariance.
// A result waits in the output register; the next word is accepted while it
// waits, but that word's result cannot be loaded until the first is taken.
module angle_kalman_filter #(
    parameter int DATA_WIDTH = akf_pkg::DATA_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [akf_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [akf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [akf_pkg::ANGLE_W-1:0] i_measured_angle,
    input  logic signed [akf_pkg::ANGLE_W-1:0] i_gyro_rate,
    input  logic [akf_pkg::DT_W-1:0]         i_time_step,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [akf_pkg::ANGLE_W-1:0] o_angle_out
);
    import akf_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int OW = ((W > 29) ? W : 29) + 2;
    localparam int EW = ((W > 29) ? W : 29) + 5;
    localparam logic signed [EW-1:0] W_MAX = {{(EW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [EW-1:0] W_MIN = {{(EW-W+1){1'b1}}, {(W-1){1'b0}}};
    localparam logic signed [EW-1:0] O_MAX = {{(EW-ANGLE_W+1){1'b0}}, {(ANGLE_W-1){1'b1}}};
    localparam logic signed [EW-1:0] O_MIN = {{(EW-ANGLE_W+1){1'b1}}, {(ANGLE_W-1){1'b0}}};

    // Sequencer steps: prediction, gains, state correction, covariance update, then the result.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_ANG   = 4'd1;
    localparam logic [3:0] ST_D     = 4'd2;
    localparam logic [3:0] ST_C00   = 4'd3;
    localparam logic [3:0] ST_C11   = 4'd4;
    localparam logic [3:0] ST_K0    = 4'd5;
    localparam logic [3:0] ST_K1    = 4'd6;
    localparam logic [3:0] ST_CA    = 4'd7;
    localparam logic [3:0] ST_CB    = 4'd8;
    localparam logic [3:0] ST_U10   = 4'd9;
    localparam logic [3:0] ST_U11   = 4'd10;
    localparam logic [3:0] ST_U00   = 4'd11;
    localparam logic [3:0] ST_U01   = 4'd12;
    localparam logic [3:0] ST_DONE  = 4'd13;

    function automatic logic signed [W-1:0] sat_w(input logic signed [EW-1:0] v);
        if (v > W_MAX) begin
            return W_MAX[W-1:0];
        end else if (v < W_MIN) begin
            return W_MIN[W-1:0];
        end
        return v[W-1:0];
    endfunction

    function automatic logic signed [EW-1:0] ext_w(input logic signed [W-1:0] v);
        return {{(EW-W){v[W-1]}}, v};
    endfunction

    function automatic logic signed [EW-1:0] ext_32(input logic signed [ANGLE_W-1:0] v);
        return {{(EW-ANGLE_W){v[ANGLE_W-1]}}, v};
    endfunction

    function automatic logic signed [OW-1:0] op_w(input logic signed [W-1:0] v);
        return {{(OW-W){v[W-1]}}, v};
    endfunction

    function automatic logic signed [EW-1:0] noise_q28(input logic [NOISE_W-1:0] v);
        return {{(EW-NOISE_W-4){1'b0}}, v, 4'b0000};
    endfunction

    // Configuration registers.
    logic [NOISE_W-1:0]       r_angle_noise, r_bias_noise, r_measure_noise;
    // Filter state.
    logic signed [W-1:0]      r_angle, r_bias, r_c00, r_c01, r_c10, r_c11;
    logic signed [W-1:0]      r_k0, r_k1, r_y;
    logic signed [EW-1:0]     r_d;
    // Captured input word.
    logic signed [ANGLE_W-1:0] r_meas, r_gyro;
    logic [DT_W-1:0]          r_dt;
    // Control.
    logic [3:0]               r_state;
    logic                     r_busy;
    logic                     r_out_valid;
    logic signed [ANGLE_W-1:0] r_angle_out;

    t_au_ctrl                 au_ctrl;
    logic signed [OW-1:0]     au_a, au_b;
    logic                     au_done;
    logic signed [EW-1:0]     au_res;

    logic signed [W-1:0]      rate, t_term;
    logic signed [EW-1:0]     s_term, ang_ext;
    logic signed [OW-1:0]     dt_op;
    logic                     arith;

    akf_serial_unit #(.DATA_WIDTH(DATA_WIDTH)) u_unit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (au_ctrl),
        .i_a      (au_a),
        .i_b      (au_b),
        .o_done   (au_done),
        .o_result (au_res)
    );

    always_comb begin
        rate   = sat_w(ext_32(r_gyro) - ext_w(r_bias));
        t_term = sat_w(r_d - ext_w(r_c01) - ext_w(r_c10) + noise_q28(r_angle_noise));
        // Innovation variance; it always fits the operand width.
        s_term = ext_w(r_c00) + noise_q28(r_measure_noise);
        dt_op  = {{(OW-DT_W){1'b0}}, r_dt};
        ang_ext = ext_w(r_angle);
        arith  = (r_state != ST_IDLE) && (r_state != ST_DONE);

        au_ctrl.start = arith && !r_busy;
        au_ctrl.op    = OP_MUL;
        au_ctrl.shift = SH_28;
        au_a = dt_op;
        au_b = dt_op;
        unique case (r_state)
            ST_ANG: begin
                au_ctrl.shift = SH_24;
                au_b = op_w(rate);
            end
            ST_D: begin
                au_ctrl.shift = SH_24;
                au_b = op_w(r_c11);
            end
            ST_C00: begin
                au_ctrl.shift = SH_24;
                au_b = op_w(t_term);
            end
            ST_C11: begin
                au_ctrl.shift = SH_20;
                au_a = {{(OW-NOISE_W){1'b0}}, r_bias_noise};
            end
            ST_K0: begin
                au_ctrl.op = OP_DIV;
                au_a = op_w(r_c00);
                au_b = s_term[OW-1:0];
            end
            ST_K1: begin
                au_ctrl.op = OP_DIV;
                au_a = op_w(r_c10);
                au_b = s_term[OW-1:0];
            end
            ST_CA: begin
                au_a = op_w(r_k0);
                au_b = op_w(r_y);
            end
            ST_CB: begin
                au_a = op_w(r_k1);
                au_b = op_w(r_y);
            end
            ST_U10: begin
                au_a = op_w(r_k1);
                au_b = op_w(r_c00);
            end
            ST_U11: begin
                au_a = op_w(r_k1);
                au_b = op_w(r_c01);
            end
            ST_U00: begin
                au_a = op_w(r_k0);
                au_b = op_w(r_c00);
            end
            ST_U01: begin
                au_a = op_w(r_k0);
                au_b = op_w(r_c01);
            end
            default: begin
                au_a = dt_op;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_noise   <= ANGLE_NOISE_RST;
            r_bias_noise    <= BIAS_NOISE_RST;
            r_measure_noise <= MEASURE_NOISE_RST;
            r_angle <= '0;
            r_bias  <= '0;
            r_c00   <= '0;
            r_c01   <= '0;
            r_c10   <= '0;
            r_c11   <= '0;
            r_state <= ST_IDLE;
            r_busy  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_ANGLE_NOISE:   r_angle_noise   <= i_cfg_data[NOISE_W-1:0];
                    CFG_BIAS_NOISE:    r_bias_noise    <= i_cfg_data[NOISE_W-1:0];
                    CFG_MEASURE_NOISE: r_measure_noise <= i_cfg_data[NOISE_W-1:0];
                    CFG_START_ANGLE:   r_angle <= sat_w(ext_32(i_cfg_data));
                    default: ;
                endcase
            end

            // In the final step a taken result is replaced by the new one below.
            if (r_out_valid && i_out_ready && (r_state != ST_DONE)) begin
                r_out_valid <= 1'b0;
            end

            if (au_ctrl.start) begin
                r_busy <= 1'b1;
            end

            if (r_state == ST_IDLE) begin
                if (i_in_valid) begin
                    r_meas  <= i_measured_angle;
                    r_gyro  <= i_gyro_rate;
                    r_dt    <= i_time_step;
                    r_state <= ST_ANG;
                end
            end else if (r_state == ST_DONE) begin
                if (!r_out_valid || i_out_ready) begin
                    r_out_valid <= 1'b1;
                    if (ang_ext > O_MAX) begin
                        r_angle_out <= O_MAX[ANGLE_W-1:0];
                    end else if (ang_ext < O_MIN) begin
                        r_angle_out <= O_MIN[ANGLE_W-1:0];
                    end else begin
                        r_angle_out <= ang_ext[ANGLE_W-1:0];
                    end
                    r_state <= ST_IDLE;
                end
            end else if (au_done) begin
                r_busy  <= 1'b0;
                r_state <= r_state + 1'b1;
                unique case (r_state)
                    ST_ANG: r_angle <= sat_w(ang_ext + au_res);
                    ST_D:   r_d <= au_res;
                    ST_C00: begin
                        r_c00 <= sat_w(ext_w(r_c00) + au_res);
                        r_c01 <= sat_w(ext_w(r_c01) - r_d);
                        r_c10 <= sat_w(ext_w(r_c10) - r_d);
                    end
                    ST_C11: r_c11 <= sat_w(ext_w(r_c11) + au_res);
                    ST_K0:  r_k0 <= au_res[W-1:0];
                    ST_K1: begin
                        r_k1 <= au_res[W-1:0];
                        r_y  <= sat_w(ext_32(r_meas) - ang_ext);
                    end
                    ST_CA:  r_angle <= sat_w(ang_ext + au_res);
                    ST_CB:  r_bias  <= sat_w(ext_w(r_bias) + au_res);
                    ST_U10: r_c10 <= sat_w(ext_w(r_c10) - au_res);
                    ST_U11: r_c11 <= sat_w(ext_w(r_c11) - au_res);
                    ST_U00: r_c00 <= sat_w(ext_w(r_c00) - au_res);
                    ST_U01: r_c01 <= sat_w(ext_w(r_c01) - au_res);
                    default: ;
                endcase
            end
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_angle_out = r_angle_out;

endmodule

/* rtl/core/akf_checker.sv */
// Port-level checker for angle_kalman_filter, with its bind statement.
// Depends on akf_pkg.
module akf_port_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready
);
    import akf_pkg::*;

    // A held result stays offered until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result word dropped before it was taken");

    // An accepted word occupies the filter for the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input accepted while the filter was still working");

    // A result appears only as the filter returns to idle.
    a_result_at_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result appeared while the filter was busy");

    // Reset leaves the filter idle with no result pending.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_ready && !o_out_valid)
        else $error("filter not idle after reset");

endmodule

bind angle_kalman_filter akf_port_checker u_akf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready)
);
